[sv/pem_pkg.sv]
package pem_pkg;

    localparam int REG_BITS   = 12;
    localparam int ROW_BITS   = REG_BITS + 1;
    localparam int PIXEL_BITS = 8;
    localparam int MAX_WIDTH_DEFAULT = 2048;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(640);
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(480);
    localparam logic [REG_BITS-1:0] MIN_SIZE     = REG_BITS'(3);

    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [PIXEL_BITS-1:0] pixel;
        logic                  frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] edge_res;
        logic                  row_end;
        logic                  frame_end;
    } out_item_t;

    // one window column, index 0 is the top row
    typedef logic [2:0][PIXEL_BITS-1:0] win_col_t;

endpackage

[sv/prewitt_edge_magnitude.sv]
// Streaming 3x3 Prewitt edge magnitude, min(255, |Gx| + |Gy|), on 8-bit grey pixels in raster
// order with reflect-101 borders. One item is taken every clock unless a result waits on a
// stalled output; results pass stage 1 and the output register and trail the pixels by one row
// plus one pixel, so width + 1 flush items (mode 1) after the last pixel push out the final
// row. The two line stores (MAX_WIDTH x 8 bits each, one read and one write port) are read
// when an item is taken and written as it leaves stage 1. The user sets frame size through the
// write port (index 0 width, index 1 height) only while the block is idle; this is not enforced.
module prewitt_edge_magnitude #(
    parameter int MAX_WIDTH = pem_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [pem_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [pem_pkg::REG_BITS-1:0]          cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  pem_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output pem_pkg::out_item_t                    m_data
);
    import pem_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WB = (CW >= REG_BITS) ? CW + 1 : REG_BITS;

    function automatic logic [PIXEL_BITS-1:0] magnitude(win_col_t l, win_col_t c, win_col_t r);
        logic [9:0]  sl, sr, st, sb;
        logic [10:0] dx, dy;
        logic [9:0]  ax, ay;
        logic [10:0] s;
        sl = 10'(l[0]) + 10'(l[1]) + 10'(l[2]);
        sr = 10'(r[0]) + 10'(r[1]) + 10'(r[2]);
        st = 10'(l[0]) + 10'(c[0]) + 10'(r[0]);
        sb = 10'(l[2]) + 10'(c[2]) + 10'(r[2]);
        dx = {1'b0, sr} - {1'b0, sl};
        dy = {1'b0, sb} - {1'b0, st};
        ax = dx[10] ? 10'(-dx) : dx[9:0];
        ay = dy[10] ? 10'(-dy) : dy[9:0];
        s  = {1'b0, ax} + {1'b0, ay};
        return (s > 11'd255) ? 8'hff : s[7:0];
    endfunction

    // configuration
    logic [REG_BITS-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [WB-1:0]       w_ext, w_eff;
    logic [REG_BITS-1:0] h_eff;
    logic [ROW_BITS-1:0] h_row, h_row_p1;

    always_comb begin
        w_ext = WB'(width_reg);
        if (width_reg < MIN_SIZE) begin
            w_eff = WB'(MIN_SIZE);
        end else if (w_ext > WB'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_eff    = (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
        h_row    = ROW_BITS'(h_eff);
        h_row_p1 = h_row + ROW_BITS'(1);
    end

    // handshake
    logic s1_valid_reg, m_valid_reg;
    logic s1_res, s1_go, out_free, accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_go    = s1_valid_reg && (!s1_res || out_free);
    assign s_ready  = !s1_valid_reg || s1_go;
    assign accept   = s_valid && s_ready;

    // position counters and item decode
    logic [CW-1:0]       col_reg, col_a, col_b, col_c;
    logic [ROW_BITS-1:0] row_reg, row_a, row_b, row_c;
    logic [WB-1:0]       col_inc;
    logic                keep, do_shift, res_a, res_b, fe_a;

    always_comb begin
        if (s_data.mode == MODE_PIXEL && s_data.frame_start) begin
            col_a = '0;
            row_a = '0;
        end else begin
            col_a = col_reg;
            row_a = row_reg;
        end
        if (WB'(col_a) >= w_eff) begin
            col_b = '0;
            row_b = row_a + ROW_BITS'(1);
        end else begin
            col_b = col_a;
            row_b = row_a;
        end
        if (s_data.mode == MODE_PIXEL) begin
            keep = row_b < h_row;
        end else begin
            keep = (row_b == h_row) || (row_b == h_row_p1 && col_b == '0);
        end
        col_inc = WB'(col_b) + WB'(1);
        if (col_inc >= w_eff) begin
            col_c = '0;
            row_c = row_b + ROW_BITS'(1);
        end else begin
            col_c = col_inc[CW-1:0];
            row_c = row_b;
        end
        do_shift = row_b <= h_row;
        res_a    = (col_b == '0) && (row_b >= ROW_BITS'(2));
        fe_a     = row_b == h_row_p1;
        res_b    = do_shift && (col_b != '0) && (row_b != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= keep ? col_c : col_b;
            row_reg <= keep ? row_c : row_b;
        end
    end

    // stage 1: item and line store read data
    logic                  s1_mode_reg, s1_res_a_reg, s1_fe_a_reg, s1_res_b_reg;
    logic                  s1_shift_reg, s1_top_mirror_reg, s1_col_is1_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [CW-1:0]         s1_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= keep;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg       <= s_data.mode;
            s1_pix_reg        <= s_data.pixel;
            s1_col_reg        <= col_b;
            s1_res_a_reg      <= res_a;
            s1_fe_a_reg       <= fe_a;
            s1_res_b_reg      <= res_b;
            s1_shift_reg      <= do_shift;
            s1_top_mirror_reg <= row_b == ROW_BITS'(1);
            s1_col_is1_reg    <= col_b == CW'(1);
        end
    end

    assign s1_res = s1_res_a_reg || s1_res_b_reg;

    logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] upper_rd_reg, lower_rd_reg;
    logic                  mem_wr;

    assign mem_wr = s1_go && s1_shift_reg && s1_mode_reg == MODE_PIXEL;

    always_ff @(posedge aclk) begin
        if (accept) begin
            upper_rd_reg <= upper_mem[col_b];
        end
        if (mem_wr) begin
            upper_mem[s1_col_reg] <= lower_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lower_rd_reg <= lower_mem[col_b];
        end
        if (mem_wr) begin
            lower_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    // window, index 0 oldest column
    win_col_t              win_reg  [3];
    win_col_t              win_next [3];
    win_col_t              new_col;
    logic [PIXEL_BITS-1:0] bot_px;
    out_item_t             res_next;

    always_comb begin
        bot_px     = (s1_mode_reg == MODE_PIXEL) ? s1_pix_reg : upper_rd_reg;
        new_col[0] = s1_top_mirror_reg ? bot_px : upper_rd_reg;
        new_col[1] = lower_rd_reg;
        new_col[2] = bot_px;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = new_col;
        if (s1_res_a_reg) begin
            res_next.edge_res  = magnitude(win_reg[1], win_reg[2], win_reg[1]);
            res_next.row_end   = 1'b1;
            res_next.frame_end = s1_fe_a_reg;
        end else begin
            res_next.edge_res  = magnitude(s1_col_is1_reg ? win_next[2] : win_next[0],
                                           win_next[1], win_next[2]);
            res_next.row_end   = 1'b0;
            res_next.frame_end = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_go && s1_shift_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // output register
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_res) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_res) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pem_pkg::*;

    class edge_scoreboard;
        logic [REG_BITS-1:0]   width_reg;
        logic [REG_BITS-1:0]   height_reg;
        logic [PIXEL_BITS-1:0] store_up [MAX_WIDTH_DEFAULT];
        logic [PIXEL_BITS-1:0] store_lo [MAX_WIDTH_DEFAULT];
        logic [PIXEL_BITS-1:0] win [3][3];
        int                    col_cnt;
        int                    row_cnt;
        int                    mismatches;
        out_item_t             edges_due [$];

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (store_up[i]) begin
                store_up[i] = '0;
                store_lo[i] = '0;
            end
            foreach (win[r, c]) win[r][c] = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = val;
            end else begin
                height_reg = val;
            end
        endfunction

        function int cols();
            int w;
            w = width_reg;
            if (w < MIN_SIZE) w = MIN_SIZE;
            if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
            return w;
        endfunction

        function int rows();
            int h;
            h = height_reg;
            if (h < MIN_SIZE) h = MIN_SIZE;
            return h;
        endfunction

        // left, centre and right window columns
        function logic [PIXEL_BITS-1:0] gradient_sum(int lc, int cc, int rc);
            int lsum, rsum, tsum, bsum, gx, gy, s;
            lsum = 0;
            rsum = 0;
            for (int k = 0; k < 3; k++) begin
                lsum += int'(win[k][lc]);
                rsum += int'(win[k][rc]);
            end
            tsum = int'(win[0][lc]) + int'(win[0][cc]) + int'(win[0][rc]);
            bsum = int'(win[2][lc]) + int'(win[2][cc]) + int'(win[2][rc]);
            gx = rsum - lsum;
            gy = bsum - tsum;
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            s = gx + gy;
            if (s > 255) s = 255;
            return s[PIXEL_BITS-1:0];
        endfunction

        function void note_item(in_item_t it);
            int w, h, c;
            logic [PIXEL_BITS-1:0] t, m, b;
            w = cols();
            h = rows();
            if (it.mode == MODE_PIXEL && it.frame_start) begin
                row_cnt = 0;
                col_cnt = 0;
            end
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (it.mode == MODE_PIXEL) begin
                if (row_cnt >= h) return;
            end else if (!(row_cnt == h || (row_cnt == h + 1 && col_cnt == 0))) begin
                return;
            end
            c = col_cnt;
            // closing result of the row before, taken before the window moves
            if (c == 0 && row_cnt >= 2)
                edges_due.push_back(out_item_t'{gradient_sum(1, 2, 1), 1'b1, row_cnt == h + 1});
            if (row_cnt <= h) begin
                t = store_up[c];
                m = store_lo[c];
                b = (it.mode == MODE_PIXEL) ? it.pixel : t;
                if (row_cnt == 1) t = b;
                if (it.mode == MODE_PIXEL) begin
                    store_up[c] = store_lo[c];
                    store_lo[c] = it.pixel;
                end
                for (int k = 0; k < 3; k++) begin
                    win[k][0] = win[k][1];
                    win[k][1] = win[k][2];
                end
                win[0][2] = t;
                win[1][2] = m;
                win[2][2] = b;
                if (c >= 1 && row_cnt >= 1)
                    edges_due.push_back(out_item_t'{gradient_sum(c == 1 ? 2 : 0, 1, 2),
                                                    1'b0, 1'b0});
            end
            col_cnt = c + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
        endfunction

        task report(string what);
            $display("%0t ns  mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_edge(out_item_t got);
            out_item_t want;
            if (edges_due.size() == 0) begin
                report($sformatf("result %p with none due", got));
            end else begin
                want = edges_due.pop_front();
                if (got.edge_res != want.edge_res)
                    report($sformatf("edge_res %0d, want %0d", got.edge_res, want.edge_res));
                if (got.row_end != want.row_end)
                    report($sformatf("row_end %0b, want %0b", got.row_end, want.row_end));
                if (got.frame_end != want.frame_end)
                    report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
            end
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [REG_BITS-1:0]       cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    in_item_t                  s_data;
    logic                      m_valid;
    logic                      m_ready;
    out_item_t                 m_data;

    edge_scoreboard sb;
    int send_idle;
    int stall_pct;
    int items_sent;
    int send_plan  [4] = '{0, 47, 0, 20};
    int stall_plan [4] = '{0, 0, 47, 20};

    prewitt_edge_magnitude dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_edge(m_data);
            if (s_valid && s_ready) sb.note_item(s_data);
        end
    end

    task automatic put(logic md, logic [PIXEL_BITS-1:0] px, logic fs);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= in_item_t'{md, px, fs};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (sb.edges_due.size() != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        if (sb.edges_due.size() != 0) begin
            sb.report($sformatf("%0d results never came", sb.edges_due.size()));
            sb.edges_due.delete();
        end
        // a trailing item may still be in flight without a result
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_frame(logic [REG_BITS-1:0] w, logic [REG_BITS-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_wdata <= w;
        sb.set_reg(CFG_IMAGE_WIDTH, w);
        @(negedge aclk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        sb.set_reg(CFG_IMAGE_HEIGHT, h);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [PIXEL_BITS-1:0] gen_pixel(int style, int base);
        int v;
        case (style)
            0: v = $urandom_range(255);
            1: v = $urandom_range(1) ? 255 : 0;
            2: v = base + int'($urandom_range(16)) - 8;
            default: v = base;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIXEL_BITS-1:0];
    endfunction

    function automatic logic [REG_BITS-1:0] pick_w();
        return REG_BITS'(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 14));
    endfunction

    function automatic logic [REG_BITS-1:0] pick_h();
        return REG_BITS'(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8));
    endfunction

    // cut_at < 0 sends the whole frame and its flush
    task automatic run_frame(int cut_at);
        int w, h, n, style, base;
        w = sb.cols();
        h = sb.rows();
        style = $urandom_range(3);
        base = $urandom_range(255);
        n = (cut_at >= 0) ? cut_at : w * h;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(99) < 2)
                put(MODE_FLUSH, PIXEL_BITS'($urandom), 1'($urandom));
            put(MODE_PIXEL, gen_pixel(style, base), i == 0);
        end
        items_sent += n;
        if (cut_at < 0) begin
            for (int i = 0; i <= w; i++) put(MODE_FLUSH, PIXEL_BITS'($urandom), 1'($urandom));
            items_sent += w + 1;
            if ($urandom_range(99) < 15) put(MODE_FLUSH, PIXEL_BITS'($urandom), 1'($urandom));
            if ($urandom_range(99) < 15) put(MODE_PIXEL, PIXEL_BITS'($urandom), 1'b0);
        end
    endtask

    initial begin
        sb = new();
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_IMAGE_WIDTH;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        send_idle  = 0;
        stall_pct  = 0;
        items_sent = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sizes below the minimum, used as 3 x 3
        set_frame(12'd1, 12'd2);
        // partial frame; its pending row result is dropped by the next frame start
        for (int i = 0; i < 6; i++) put(MODE_PIXEL, PIXEL_BITS'($urandom), i == 0);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) put(MODE_FLUSH, 8'hFF, 1'b1);
            put(MODE_PIXEL, (i % 2) ? 8'hFF : 8'h00, i == 0);
        end
        for (int i = 0; i < 4; i++) put(MODE_FLUSH, 8'h00, 1'b0);
        put(MODE_FLUSH, 8'hA5, 1'b1);
        put(MODE_PIXEL, 8'h5A, 1'b0);
        drain();

        // width shrinks under the current column
        set_frame(12'd4, 12'd3);
        for (int i = 0; i < 7; i++) put(MODE_PIXEL, PIXEL_BITS'($urandom), i == 0);
        drain();
        set_frame(12'd3, 12'd3);
        for (int i = 0; i < 3; i++) put(MODE_PIXEL, PIXEL_BITS'($urandom), 1'b0);
        for (int i = 0; i < 4; i++) put(MODE_FLUSH, PIXEL_BITS'($urandom), 1'($urandom));
        drain();

        for (int p = 0; p < 4; p++) begin
            send_idle = send_plan[p];
            stall_pct = stall_plan[p];
            if (p == 0) begin
                // tallest height on a cut-off frame
                set_frame(12'd3, 12'hFFF);
                run_frame(36);
                drain();
                set_frame(pick_w(), pick_h());
                items_sent = 0;
            end
            while (items_sent < (p + 1) * 415) begin
                if ($urandom_range(99) < 30) begin
                    drain();
                    set_frame(pick_w(), pick_h());
                end
                if ($urandom_range(9) == 0) begin
                    run_frame($urandom_range(1, sb.cols() * sb.rows() - 1));
                end else begin
                    run_frame(-1);
                end
            end
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
